>>> rtl/ibr_pkg.sv
// Shared constants for the indexed block reassembler.
`timescale 1ns / 1ps

package ibr_pkg;

  localparam int BUF_BYTES    = 128;
  localparam int PACKET_BYTES = 32;

  // payload bytes per packet and highest block index that still lands in the store
  localparam int BLK_BYTES = PACKET_BYTES - 1;
  localparam int TOP_INDEX = BUF_BYTES / BLK_BYTES;

  // store is kept as 64-bit words
  localparam int WORD_BYTES = 8;
  localparam int WORD_W     = 64;
  localparam int WORDS      = (BUF_BYTES + WORD_BYTES - 1) / WORD_BYTES;
  localparam int WA_W       = $clog2(WORDS);

  localparam int IDX_W    = 8;
  localparam int LEN_W    = 8;
  localparam int ADDR_W   = $clog2(BUF_BYTES + 1);
  localparam int HI_W     = $clog2(TOP_INDEX + 1);
  localparam int BSEL_W   = $clog2(BLK_BYTES + 1);
  localparam int PAY_W    = BLK_BYTES * 8;
  localparam int PAYALL_W = 248;

endpackage

>>> rtl/ibr_if.sv
// Handshake channels for packets in and message words out.
`timescale 1ns / 1ps

interface ibr_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  blk_idx;
  logic [63:0] payload_a;
  logic [63:0] payload_b;
  logic [63:0] payload_c;
  logic [55:0] payload_d;

  modport source (output valid, blk_idx, payload_a, payload_b, payload_c, payload_d,
                  input ready);
  modport sink   (input valid, blk_idx, payload_a, payload_b, payload_c, payload_d,
                  output ready);
endinterface

interface ibr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] msg_word;
  logic [7:0]  msg_length;
  logic        word_last;

  modport source (output valid, msg_word, msg_length, word_last, input ready);
  modport sink   (input valid, msg_word, msg_length, word_last, output ready);
endinterface

>>> rtl/ibr_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps

module ibr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/indexed_block_reassembler.sv
// Indexed block reassembler: packets merged into a word store, delivered on block 0.
//
//   channel  | dir | carries
//   in_chan  | in  | blk_idx, payload_a..payload_d (one radio packet)
//   out_chan | out | msg_word, msg_length, word_last (one store word)
//
// A packet is written by read-modify-write of the 64-bit store words it covers (at
// most five), a read state then a write state per word; the next packet is taken when
// its last word is written, and a dropped one (index above TOP_INDEX) leaves the block idle.
// A closing packet (index 0) covers four words, then reads out ceil(length/8) words
// through the registered RAM read port; in_ready is high only between packets.
// Reset is synchronous; a valid bit per store word makes unwritten words read as zero.
// The output register holds a word until taken; a stalled sink pauses the read-out.
`timescale 1ns / 1ps

module indexed_block_reassembler (
  input  logic clk,
  input  logic rst_n,
  ibr_in_if.sink     in_chan,
  ibr_out_if.source  out_chan
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_WR   = 3'd2;
  localparam logic [2:0] S_DRD  = 3'd3;
  localparam logic [2:0] S_DLD  = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  logic [ibr_pkg::HI_W-1:0]    hi_r, hi_nxt;
  logic [ibr_pkg::WORDS-1:0]   vld_r, vld_nxt;
  logic                        vld_rd_r, vld_rd_nxt;
  logic                        close_r, close_nxt;
  logic [ibr_pkg::ADDR_W-1:0]  base_r, base_nxt;
  logic [ibr_pkg::ADDR_W-1:0]  end_r, end_nxt;
  logic [ibr_pkg::ADDR_W-1:0]  len_r, len_nxt;
  logic [ibr_pkg::WA_W-1:0]    w_r, w_nxt;
  logic [ibr_pkg::WA_W-1:0]    wl_r, wl_nxt;
  logic [ibr_pkg::WA_W-1:0]    dl_r, dl_nxt;
  logic [ibr_pkg::PAY_W-1:0]   pay_r, pay_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [63:0]                 out_word_r, out_word_nxt;
  logic [7:0]                  out_len_r, out_len_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        ram_we, ram_re;
  logic [ibr_pkg::WA_W-1:0]    ram_waddr, ram_raddr;
  logic [ibr_pkg::WORD_W-1:0]  ram_wdata, ram_rdata, rd_word;
  logic                        in_acc, out_free;

  ibr_ram #(
    .WIDTH (ibr_pkg::WORD_W),
    .DEPTH (ibr_pkg::WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_chan.ready       = (state_r == S_IDLE);
  assign in_acc              = in_chan.valid && in_chan.ready;
  assign out_free            = !out_valid_r || out_chan.ready;
  assign rd_word             = vld_rd_r ? ram_rdata : '0;

  assign out_chan.valid      = out_valid_r;
  assign out_chan.msg_word   = out_word_r;
  assign out_chan.msg_length = out_len_r;
  assign out_chan.word_last  = out_last_r;

  // byte merge of the packet into the word just read
  always_comb begin
    logic [ibr_pkg::ADDR_W-1:0] a;
    logic [ibr_pkg::BSEL_W-1:0] k;
    ram_wdata = rd_word;
    for (int b = 0; b < ibr_pkg::WORD_BYTES; b++) begin
      a = ibr_pkg::ADDR_W'({w_r, 3'(b)});
      k = ibr_pkg::BSEL_W'(a - base_r);
      if (a >= base_r && a < end_r) begin
        ram_wdata[b*8 +: 8] = pay_r[k*8 +: 8];
      end
    end
  end

  always_comb begin
    logic [31:0]                  idx32, hi32, base32, end32, len32;
    logic [ibr_pkg::PAYALL_W-1:0] pay_all;

    state_nxt     = state_r;
    hi_nxt        = hi_r;
    vld_nxt       = vld_r;
    vld_rd_nxt    = vld_rd_r;
    close_nxt     = close_r;
    base_nxt      = base_r;
    end_nxt       = end_r;
    len_nxt       = len_r;
    w_nxt         = w_r;
    wl_nxt        = wl_r;
    dl_nxt        = dl_r;
    pay_nxt       = pay_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = w_r;
    ram_raddr     = w_r;

    idx32   = 32'(in_chan.blk_idx);
    hi32    = (idx32 > 32'(hi_r)) ? idx32 : 32'(hi_r);
    base32  = idx32 * 32'(ibr_pkg::BLK_BYTES);
    end32   = base32 + 32'(ibr_pkg::BLK_BYTES);
    if (end32 > 32'(ibr_pkg::BUF_BYTES)) begin
      end32 = 32'(ibr_pkg::BUF_BYTES);
    end
    len32   = (hi32 + 32'd1) * 32'(ibr_pkg::BLK_BYTES);
    if (len32 > 32'(ibr_pkg::BUF_BYTES)) begin
      len32 = 32'(ibr_pkg::BUF_BYTES);
    end
    pay_all = {in_chan.payload_d, in_chan.payload_c, in_chan.payload_b, in_chan.payload_a};

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && idx32 <= 32'(ibr_pkg::TOP_INDEX)) begin
          pay_nxt   = pay_all[ibr_pkg::PAY_W-1:0];
          base_nxt  = ibr_pkg::ADDR_W'(base32);
          end_nxt   = ibr_pkg::ADDR_W'(end32);
          w_nxt     = ibr_pkg::WA_W'(base32 >> 3);
          wl_nxt    = ibr_pkg::WA_W'((end32 - 32'd1) >> 3);
          close_nxt = (idx32 == 32'd0);
          len_nxt   = ibr_pkg::ADDR_W'(len32);
          dl_nxt    = ibr_pkg::WA_W'((len32 - 32'd1) >> 3);
          // the closing packet delivers now, so the highest index restarts here
          hi_nxt    = (idx32 == 32'd0) ? '0 : ibr_pkg::HI_W'(hi32);
          if (end32 > base32) begin
            state_nxt = S_RD;
          end else if (idx32 == 32'd0) begin
            w_nxt     = '0;
            state_nxt = S_DRD;
          end
        end
      end
      S_RD: begin
        ram_re     = 1'b1;
        vld_rd_nxt = vld_r[w_r];
        state_nxt  = S_WR;
      end
      S_WR: begin
        ram_we       = 1'b1;
        vld_nxt[w_r] = 1'b1;
        if (w_r == wl_r) begin
          if (close_r) begin
            w_nxt     = '0;
            state_nxt = S_DRD;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          w_nxt     = w_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_DRD: begin
        ram_re     = 1'b1;
        vld_rd_nxt = vld_r[w_r];
        state_nxt  = S_DLD;
      end
      S_DLD: begin
        // read data holds in the RAM register until the output stage is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = rd_word;
          out_len_nxt   = 8'(len_r);
          out_last_nxt  = (w_r == dl_r);
          if (w_r == dl_r) begin
            state_nxt = S_IDLE;
          end else begin
            w_nxt     = w_r + 1'b1;
            state_nxt = S_DRD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hi_r        <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hi_r        <= hi_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vld_rd_r   <= vld_rd_nxt;
    close_r    <= close_nxt;
    base_r     <= base_nxt;
    end_r      <= end_nxt;
    len_r      <= len_nxt;
    w_r        <= w_nxt;
    wl_r       <= wl_nxt;
    dl_r       <= dl_nxt;
    pay_r      <= pay_nxt;
    out_word_r <= out_word_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
